/* hdl/binary_min_heap_priority_queue_top_assert.svh */
// assertion macros used by the queue checker
`ifndef BINARY_MIN_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define BINARY_MIN_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define BMHPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmhpq assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define BMHPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmhpq assertion failed");

`endif

/* hdl/bmhpq_pkg.sv */
// types and constants of the priority queue
package bmhpq_pkg;

    localparam int KEY_W = 32;
    localparam int CAP_W = 7;
    localparam int ST_W  = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    localparam logic signed [KEY_W-1:0] KEY_EMPTY = -32'sd1;

    typedef struct packed {
        logic                    req_type;
        logic signed [KEY_W-1:0] key_in;
    } req_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key_out;
        logic [ST_W-1:0]         status;
    } res_t;

    // operation broadcast to every cell
    typedef struct packed {
        logic                    push;
        logic                    pop;
        logic signed [KEY_W-1:0] key;
    } cell_op_t;

    // what a cell shows its neighbors
    typedef struct packed {
        logic                    valid;
        logic                    less;
        logic signed [KEY_W-1:0] key;
    } cell_link_t;

endpackage

/* hdl/bmhpq_cell.sv */
// one slot of the sorted key chain
module bmhpq_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bmhpq_pkg::cell_op_t   op,
    input  bmhpq_pkg::cell_link_t left,
    input  bmhpq_pkg::cell_link_t right,
    output bmhpq_pkg::cell_link_t self
);
    import bmhpq_pkg::*;

    logic                    valid_reg;
    logic                    valid_next;
    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic                    less;

    // an empty slot counts as larger than any key
    assign less = !valid_reg || (op.key < key_reg);

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        if (op.pop)
        begin
            valid_next = right.valid;
            key_next   = right.key;
        end
        else if (op.push)
        begin
            if (left.less)
            begin
                valid_next = left.valid;
                key_next   = left.key;
            end
            else if (less)
            begin
                valid_next = 1'b1;
                key_next   = op.key;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign self.valid = valid_reg;
    assign self.less  = less;
    assign self.key   = key_reg;

endmodule

/* hdl/bmhpq_out_buf.sv */
// two-entry result buffer: output register plus skid stage
module bmhpq_out_buf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  bmhpq_pkg::res_t load_data,
    output logic            full,
    output logic            out_valid,
    input  logic            out_stall,
    output bmhpq_pkg::res_t out_data
);
    import bmhpq_pkg::*;

    logic out_valid_reg;
    logic out_valid_next;
    res_t out_data_reg;
    res_t out_data_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    res_t skid_data_reg;
    res_t skid_data_next;
    logic out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = load;
                skid_data_next  = load_data;
            end
            else
            begin
                out_valid_next = load;
                out_data_next  = load_data;
            end
        end
        else if (load)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = load_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* hdl/binary_min_heap_priority_queue_top.sv */
// top level of the min priority queue built as a sorted chain of cells
// Min priority queue of signed 32-bit keys. A request transfer either pushes
// key_in or pops the smallest key held; each request gives exactly one result
// transfer (key_out, status). Keys live in a row of DEPTH cells kept in
// ascending order, cell 0 holding the minimum. Every cell compares the pushed
// key with its own in parallel and either keeps its key, takes the new key or
// takes its left neighbor's key; a pop shifts the whole row one cell left. The
// single compare-and-select step of the cell row is combinational, so a
// request is taken every cycle while in_stall is low, and its result is
// registered in a two-entry output buffer that lets a new request in while a
// result waits under out_stall; in_stall rises only when both entries hold
// results. A push while the count has reached the capacity register (capped
// at DEPTH) is dropped with status full and key 0; a pop on an empty queue
// returns key -1 with status empty. The capacity register takes a write on
// every cfg transfer (cfg_ready is always high) and resets to 64; write it
// only while the queue is idle. No clearing pass is needed after reset.
module binary_min_heap_priority_queue_top #(
    parameter int DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  bmhpq_pkg::req_t                   in_data,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output bmhpq_pkg::res_t                   out_data,
    // capacity register write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bmhpq_pkg::CAP_W-1:0]       cfg_data
);
    import bmhpq_pkg::*;

    // count width holds 0..DEPTH
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    logic [CAP_W-1:0] capacity_reg;
    logic [CAP_W-1:0] capacity_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    logic             accept;
    logic             is_push;
    logic             is_pop;
    logic             full;
    logic             empty;
    logic [CMPW-1:0]  count_ext;
    logic [CMPW-1:0]  cap_ext;

    cell_op_t         op;
    cell_link_t       links [DEPTH];
    cell_link_t       edge_link;
    res_t             result;

    // request transfer
    assign accept  = in_valid && !in_stall;
    assign is_push = accept && (in_data.req_type == REQ_PUSH);
    assign is_pop  = accept && (in_data.req_type == REQ_POP);

    // full when count reached capacity or the built depth
    assign count_ext = CMPW'(count_reg);
    assign cap_ext   = CMPW'(capacity_reg);
    assign full      = (count_ext >= cap_ext) || (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);

    // operation broadcast to the cell row
    assign op.push = is_push && !full;
    assign op.pop  = is_pop && !empty;
    assign op.key  = in_data.key_in;

    // boundary of the row: nothing left of cell 0, nothing right of the last
    assign edge_link.valid = 1'b0;
    assign edge_link.less  = 1'b0;
    assign edge_link.key   = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            bmhpq_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .op    (op),
                .left  (edge_link),
                .right (links[i+1]),
                .self  (links[i])
            );
        end
        else if (i == DEPTH - 1)
        begin : g_last
            bmhpq_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .op    (op),
                .left  (links[i-1]),
                .right (edge_link),
                .self  (links[i])
            );
        end
        else
        begin : g_mid
            bmhpq_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .op    (op),
                .left  (links[i-1]),
                .right (links[i+1]),
                .self  (links[i])
            );
        end
    end

    // result of the current request
    always_comb
    begin
        result.key_out = '0;
        result.status  = ST_OK;
        if (in_data.req_type == REQ_PUSH)
        begin
            if (full)
            begin
                result.status = ST_FULL;
            end
        end
        else if (empty)
        begin
            result.key_out = KEY_EMPTY;
            result.status  = ST_EMPTY;
        end
        else
        begin
            result.key_out = links[0].key;
        end
    end

    // entry count and capacity register
    always_comb
    begin
        count_next = count_reg;
        if (op.push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (op.pop)
        begin
            count_next = count_reg - CW'(1);
        end
        capacity_next = capacity_reg;
        if (cfg_valid && cfg_ready)
        begin
            capacity_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            capacity_reg <= CAP_RESET;
        end
        else
        begin
            count_reg    <= count_next;
            capacity_reg <= capacity_next;
        end
    end

    assign cfg_ready = 1'b1;

    // result buffer toward the consumer
    bmhpq_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_data (result),
        .full      (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* hdl/bmhpq_checker.sv */
// port-level checks of the priority queue, bound to the top level
`include "binary_min_heap_priority_queue_top_assert.svh"

module bmhpq_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            out_valid,
    input logic            out_stall,
    input bmhpq_pkg::res_t out_data
);
    import bmhpq_pkg::*;

    logic res_empty;
    logic res_full;

    // offered result carrying an empty or a full status
    assign res_empty = out_valid && (out_data.status == ST_EMPTY);
    assign res_full  = out_valid && (out_data.status == ST_FULL);

    // a stalled result stays offered
    `BMHPQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    // status carries a defined code only
    `BMHPQ_ASSERT_NOW(a_status_code, out_valid, out_data.status <= ST_EMPTY)
    // empty pop returns minus one
    `BMHPQ_ASSERT_NOW(a_empty_key, res_empty, out_data.key_out == KEY_EMPTY)
    // dropped push returns zero
    `BMHPQ_ASSERT_NOW(a_full_key, res_full, out_data.key_out == '0)

endmodule

bind binary_min_heap_priority_queue_top bmhpq_checker u_bmhpq_checker (.*);

/* tb/sv/binary_min_heap_priority_queue_top_test.sv */
// self-checking testbench for the min priority queue top level
module binary_min_heap_priority_queue_top_test;

    import bmhpq_pkg::*;

    localparam int                      HEAP_DEPTH = 64;
    localparam logic signed [KEY_W-1:0] KEY_MAX    = 32'sh7fff_ffff;
    localparam logic signed [KEY_W-1:0] KEY_MIN    = 32'sh8000_0000;
    localparam int                      PHASES     = 10;
    localparam int                      PHASE_ITEMS = 135;

    // directed table rows: a push, a pop, or a capacity write
    typedef enum logic [1:0] {ROW_PUSH, ROW_POP, ROW_CAP} row_kind_e;

    // receiver back-pressure patterns
    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

    typedef struct {
        row_kind_e               kind;
        logic signed [KEY_W-1:0] value;
        bit                      fixed_on;
        res_t                    fixed_res;
    } table_row_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // block inputs, all known from time zero
    logic        in_valid  = 1'b0;
    req_t        in_data   = '0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [CAP_W-1:0] cfg_data = '0;

    logic        in_stall;
    logic        out_valid;
    res_t        out_data;
    logic        cfg_ready;

    // a directed row may carry a typed-in result that replaces the prediction
    bit          fixed_on  = 1'b0;
    res_t        fixed_res = '0;

    binary_min_heap_priority_queue_top #(
        .DEPTH (HEAP_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // shadow heap: keys, fill level and capacity as the block should hold them
    // ------------------------------------------------------------------
    logic signed [KEY_W-1:0] heap_keys [HEAP_DEPTH];
    int unsigned             heap_fill = 0;
    logic [CAP_W-1:0]        heap_cap  = CAP_RESET;

    res_t        pending_results[$];
    int unsigned error_count = 0;
    int unsigned burst_left  = 0;

    table_row_t  directed_rows[$];

    // one line per mismatch
    task automatic report_mismatch(input string msg);
        error_count++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // push appends and sifts up on strict less-than; pop takes the root,
    // moves the last entry up and sifts down, left child winning ties
    function automatic res_t heap_request(input req_t req);
        int unsigned             room;
        int unsigned             node;
        int unsigned             parent;
        int unsigned             left;
        int unsigned             right;
        int unsigned             best;
        logic signed [KEY_W-1:0] held;
        bit                      done;
        res_t                    res;
        room = (heap_cap > HEAP_DEPTH) ? HEAP_DEPTH : heap_cap;
        res.key_out = '0;
        res.status  = ST_OK;
        done        = 1'b0;
        if (req.req_type == REQ_PUSH)
        begin
            if (heap_fill >= room)
                res.status = ST_FULL;
            else
            begin
                heap_keys[heap_fill] = req.key_in;
                node = heap_fill;
                heap_fill++;
                while (node > 0 && !done)
                begin
                    parent = (node - 1) / 2;
                    if (heap_keys[node] < heap_keys[parent])
                    begin
                        held              = heap_keys[node];
                        heap_keys[node]   = heap_keys[parent];
                        heap_keys[parent] = held;
                        node              = parent;
                    end
                    else
                        done = 1'b1;
                end
            end
        end
        else if (heap_fill == 0)
        begin
            res.key_out = KEY_EMPTY;
            res.status  = ST_EMPTY;
        end
        else
        begin
            res.key_out  = heap_keys[0];
            heap_fill--;
            heap_keys[0] = heap_keys[heap_fill];
            node = 0;
            while (!done)
            begin
                left  = 2 * node + 1;
                right = 2 * node + 2;
                best  = node;
                if (left >= heap_fill)
                    done = 1'b1;
                else
                begin
                    if (heap_keys[left] < heap_keys[best])
                        best = left;
                    if (right < heap_fill && heap_keys[right] < heap_keys[best])
                        best = right;
                    if (best == node)
                        done = 1'b1;
                    else
                    begin
                        held            = heap_keys[node];
                        heap_keys[node] = heap_keys[best];
                        heap_keys[best] = held;
                        node            = best;
                    end
                end
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // watch both channels at every edge: predict on request transfers,
    // compare on result transfers, and pick the next stall value
    // ------------------------------------------------------------------
    stall_mode_e stall_mode = STALL_NONE;
    int unsigned stall_left = 0;
    int unsigned stall_tick = 0;

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            // the prediction always runs so the shadow heap stays in step
            if (in_valid && !in_stall)
            begin
                want = heap_request(in_data);
                if (fixed_on)
                    want = fixed_res;
                pending_results.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("result with nothing pending, key %0d status %0d",
                                              out_data.key_out, out_data.status));
                else
                begin
                    want = pending_results.pop_front();
                    if (out_data.key_out !== want.key_out)
                        report_mismatch($sformatf("key_out %0d, wanted %0d",
                                                  out_data.key_out, want.key_out));
                    if (out_data.status !== want.status)
                        report_mismatch($sformatf("status %0d, wanted %0d",
                                                  out_data.status, want.status));
                end
            end
        end

        // the receiver switches to a new random pattern when its random run ends
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_e'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 200);
        end
        else
            stall_left--;
        stall_tick++;
        case (stall_mode)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: out_stall <= ((stall_tick % 5) < 2);
            default:        out_stall <= 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // one request transfer; bursts of random length with idle gaps between,
    // and now and then a long burst with no gap at all
    task automatic send_request(input req_t req, input bit use_fixed, input res_t typed_res);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(10, 20)) @(posedge clk);
            else
                repeat ($urandom_range(1, 5)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                    : $urandom_range(1, 12);
        end
        burst_left--;
        in_valid  <= 1'b1;
        in_data   <= req;
        fixed_on  <= use_fixed;
        fixed_res <= typed_res;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
    endtask

    // stop sending and wait until every pending result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // capacity write, only ever issued with the queue drained
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        heap_cap = cap;
    endtask

    function automatic void add_row(input row_kind_e kind, input logic signed [KEY_W-1:0] value,
                                    input bit use_fixed, input logic signed [KEY_W-1:0] fixed_key,
                                    input logic [ST_W-1:0] fixed_status);
        table_row_t row;
        row.kind              = kind;
        row.value             = value;
        row.fixed_on          = use_fixed;
        row.fixed_res.key_out = fixed_key;
        row.fixed_res.status  = fixed_status;
        directed_rows.push_back(row);
    endfunction

    // full-range keys, plus a narrow band for ties and the extremes
    function automatic logic signed [KEY_W-1:0] random_key();
        logic signed [KEY_W-1:0] key;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: key = $urandom;
            4, 5, 6:    key = $signed($urandom_range(0, 16)) - 8;
            7:          key = $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
            8:          key = KEY_MAX - $signed($urandom_range(0, 3));
            default:    key = KEY_MIN + $signed($urandom_range(0, 3));
        endcase
        return key;
    endfunction

    // capacity and push share of each random phase: fill deep at full size,
    // drop below the fill level, saturate above the built depth, shut off
    // pushes entirely, run at the smallest sizes, and finally drain
    logic [CAP_W-1:0] phase_cap [PHASES] = '{7'd64, 7'd5, 7'd127, 7'd0, 7'd1,
                                             7'd2, 7'd100, 7'd33, 7'd64, 7'd64};
    int unsigned phase_push [PHASES] = '{75, 45, 85, 50, 50, 55, 30, 65, 50, 15};

    initial
    begin
        req_t       req;
        table_row_t row;

        // directed part: typed-in results only where they are obvious
        add_row(ROW_POP,  0,        1, KEY_EMPTY, ST_EMPTY);   // pop on empty
        add_row(ROW_PUSH, KEY_MAX,  1, 0,         ST_OK);
        add_row(ROW_PUSH, KEY_MIN,  1, 0,         ST_OK);
        add_row(ROW_PUSH, 0,        0, 0,         ST_OK);
        add_row(ROW_PUSH, -1,       0, 0,         ST_OK);
        add_row(ROW_PUSH, 0,        0, 0,         ST_OK);      // duplicate key
        add_row(ROW_POP,  0,        1, KEY_MIN,   ST_OK);
        add_row(ROW_POP,  0,        0, 0,         ST_OK);
        add_row(ROW_POP,  0,        0, 0,         ST_OK);
        add_row(ROW_POP,  0,        0, 0,         ST_OK);
        add_row(ROW_POP,  0,        1, KEY_MAX,   ST_OK);
        add_row(ROW_POP,  0,        1, KEY_EMPTY, ST_EMPTY);
        add_row(ROW_CAP,  0,        0, 0,         ST_OK);      // no room at all
        add_row(ROW_PUSH, 7,        1, 0,         ST_FULL);
        add_row(ROW_POP,  0,        1, KEY_EMPTY, ST_EMPTY);
        add_row(ROW_CAP,  1,        0, 0,         ST_OK);
        add_row(ROW_PUSH, 3,        1, 0,         ST_OK);
        add_row(ROW_PUSH, 4,        1, 0,         ST_FULL);
        add_row(ROW_CAP,  127,      0, 0,         ST_OK);      // beyond built depth
        add_row(ROW_PUSH, 9,        0, 0,         ST_OK);
        add_row(ROW_PUSH, -9,       0, 0,         ST_OK);
        add_row(ROW_CAP,  1,        0, 0,         ST_OK);      // lowered under fill
        add_row(ROW_PUSH, 1,        1, 0,         ST_FULL);
        add_row(ROW_POP,  0,        0, 0,         ST_OK);
        add_row(ROW_POP,  0,        0, 0,         ST_OK);
        add_row(ROW_PUSH, 2,        1, 0,         ST_FULL);
        add_row(ROW_POP,  0,        0, 0,         ST_OK);
        add_row(ROW_POP,  0,        1, KEY_EMPTY, ST_EMPTY);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_CAP)
                write_capacity(row.value[CAP_W-1:0]);
            else
            begin
                req.req_type = (row.kind == ROW_POP) ? REQ_POP : REQ_PUSH;
                // a pop's key is ignored, so let it carry noise
                req.key_in   = (row.kind == ROW_POP) ? $signed($urandom) : row.value;
                send_request(req, row.fixed_on, row.fixed_res);
            end
        end

        // random part, checked against the shadow heap only
        for (int p = 0; p < PHASES; p++)
        begin
            write_capacity(phase_cap[p]);
            repeat (PHASE_ITEMS)
            begin
                req.req_type = ($urandom_range(0, 99) < phase_push[p]) ? REQ_PUSH : REQ_POP;
                req.key_in   = random_key();
                send_request(req, 1'b0, '0);
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (error_count == 0)
            $display("[binary_min_heap_priority_queue_top] OK");
        else
            $display("[binary_min_heap_priority_queue_top] ERROR");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #4000000;
        $display("[binary_min_heap_priority_queue_top] ERROR");
        $finish;
    end

endmodule
